### rtl/mf_pkg.sv
// Shared types, constants and compare helpers for the 3x3 median filter.
// No dependencies; mf_if, the unit and the bench use this package.
`timescale 1ns / 1ps
`default_nettype none

package mf_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned IMG_W_BITS = 12;
  localparam int unsigned IMG_H_BITS = 13;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned FLUSH_W    = 13;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // input word commands
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam int unsigned RESET_HEIGHT = 480;
  localparam int unsigned MAX_HEIGHT   = 4096;
  localparam int unsigned MIN_DIM      = 3;

  typedef logic [PIX_W-1:0] pix_t;

  // control that travels with each word down the pipeline
  typedef struct packed {
    logic valid;     // stage holds a word
    logic is_pix;    // pixel word (not a flush tick)
    logic ovalid;    // result has out_valid set
    logic olast;     // result closes the frame
    logic need_med;  // interior position: result is the median
  } stage_ctrl_t;

  typedef struct packed {
    pix_t hi;
    pix_t mid;
    pix_t lo;
  } sort3_t;

  function automatic sort3_t sort3(input pix_t a, input pix_t b, input pix_t c);
    pix_t   x;
    pix_t   y;
    pix_t   z;
    pix_t   t;
    sort3_t r;
    x = a;
    y = b;
    z = c;
    if (x > y) begin t = x; x = y; y = t; end
    if (y > z) begin t = y; y = z; z = t; end
    if (x > y) begin t = x; x = y; y = t; end
    r.lo  = x;
    r.mid = y;
    r.hi  = z;
    return r;
  endfunction

  function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
    pix_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
    pix_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    sort3_t s;
    s = sort3(a, b, c);
    return s.mid;
  endfunction

endpackage

`default_nettype wire

### rtl/mf_if.sv
// Valid/ready stream interfaces for the median filter input and output words.
// Depends on mf_pkg for the pixel width.
`timescale 1ns / 1ps
`default_nettype none

interface mf_in_if;
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [mf_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output cmd, output pixel, input ready);
  modport sink   (input valid, input cmd, input pixel, output ready);
endinterface

interface mf_out_if;
  logic                     valid;
  logic                     ready;
  logic [mf_pkg::PIX_W-1:0] out_pixel;
  logic                     out_valid;
  logic                     out_last;

  modport source (output valid, output out_pixel, output out_valid, output out_last,
                  input ready);
  modport sink   (input valid, input out_pixel, input out_valid, input out_last,
                  output ready);
endinterface

`default_nettype wire

### rtl/mf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  wire                                         clk_i,
  input  wire                                         we_i,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]                            wdata_i,
  input  wire                                         re_i,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/median_filter_3x3_unit.sv
// 3x3 median filter: two line-buffer RAMs, a 3x3 window and a median network.
// An accepted word passes the s1, s2, s3 and output registers before its output.
// Throughput: one word per clock; the only stall is back-pressure on the output.
// Line buffers are read at column c on accept and written as the word leaves s1.
// Reset: 640x480 geometry, counters and window cleared, line buffers left as is.
// Depends on mf_pkg, mf_if (mf_in_if, mf_out_if) and mf_ram.
`timescale 1ns / 1ps
`default_nettype none

module median_filter_3x3_unit #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned PIXEL_BITS = 8
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [mf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire  [mf_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  mf_in_if.sink                            in_if,
  mf_out_if.source                         out_if
);

  import mf_pkg::*;

  localparam int unsigned AW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RESET_W = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;
  localparam int unsigned MASK_B  = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;
  localparam pix_t        PIX_MASK = pix_t'((1 << MASK_B) - 1);

  // geometry, stored as last column / last row
  logic [AW-1:0]    w_last_q, w_last_d;
  logic [ROW_W-1:0] h_last_q, h_last_d;

  logic [AW-1:0]      col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [FLUSH_W-1:0] flush_q, flush_d;

  pix_t window_q [9];
  pix_t window_d [9];

  stage_ctrl_t s0_ctrl;
  stage_ctrl_t s1_q, s2_q, s3_q;
  logic [AW-1:0] s1_col_q;
  pix_t          s1_pix_q;

  sort3_t colsort_d [3];
  sort3_t colsort_q [3];

  logic out_valid_q;
  pix_t out_pix_q;
  logic out_ovalid_q;
  logic out_olast_q;

  logic adv;
  logic in_acc;
  logic is_pix;
  logic flush_owed;
  pix_t up1, up2;
  pix_t med;
  pix_t pix_in;

  logic [13:0]      w_clamp;
  logic [13:0]      w_raw;
  logic [13:0]      h_clamp;
  logic [13:0]      h_raw;

  // whole pipeline moves together; stalls only when the output word is held
  assign adv        = !out_valid_q || out_if.ready;
  assign in_if.ready = adv;
  assign in_acc     = in_if.valid && adv;
  assign is_pix     = (in_if.cmd == CMD_PIXEL);
  assign flush_owed = (flush_q != '0);
  assign pix_in     = in_if.pixel & PIX_MASK;

  // ---------------- config clamp ----------------
  always_comb begin
    w_raw   = {2'b00, cfg_wdata_i[IMG_W_BITS-1:0]};
    h_raw   = {1'b0, cfg_wdata_i[IMG_H_BITS-1:0]};
    w_clamp = w_raw;
    if (w_raw < 14'(MIN_DIM)) begin
      w_clamp = 14'(MIN_DIM);
    end else if (w_raw > 14'(MAX_WIDTH)) begin
      w_clamp = 14'(MAX_WIDTH);
    end
    h_clamp = h_raw;
    if (h_raw < 14'(MIN_DIM)) begin
      h_clamp = 14'(MIN_DIM);
    end else if (h_raw > 14'(MAX_HEIGHT)) begin
      h_clamp = 14'(MAX_HEIGHT);
    end
  end

  // ---------------- stage 0: counters and result flags ----------------
  always_comb begin
    s0_ctrl.valid    = in_acc;
    s0_ctrl.is_pix   = is_pix;
    s0_ctrl.ovalid   = flush_owed ||
                       (is_pix && ((row_q >= ROW_W'(2)) ||
                                   ((row_q == ROW_W'(1)) && (col_q != '0))));
    s0_ctrl.olast    = (flush_q == FLUSH_W'(1));
    s0_ctrl.need_med = !flush_owed && is_pix &&
                       (row_q >= ROW_W'(2)) && (col_q >= AW'(2));
  end

  always_comb begin
    w_last_d = w_last_q;
    h_last_d = h_last_q;
    col_d    = col_q;
    row_d    = row_q;
    flush_d  = flush_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_WIDTH:  w_last_d = AW'(w_clamp - 14'd1);
        REG_IMAGE_HEIGHT: h_last_d = ROW_W'(h_clamp - 14'd1);
        default: ;
      endcase
      col_d   = '0;
      row_d   = '0;
      flush_d = '0;
    end else if (in_acc) begin
      if (flush_owed) begin
        flush_d = flush_q - FLUSH_W'(1);
      end
      if (is_pix) begin
        if (col_q == w_last_q) begin
          col_d = '0;
          if (row_q == h_last_q) begin
            row_d   = '0;
            // tail of the frame: W + 1 border words still owed
            flush_d = FLUSH_W'(w_last_q) + FLUSH_W'(2);
          end else begin
            row_d = row_q + ROW_W'(1);
          end
        end else begin
          col_d = col_q + AW'(1);
        end
      end
    end
  end

  // ---------------- line buffers ----------------
  // bank A holds the row above, bank B the row two above
  mf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_a (
    .clk_i   (clk_i),
    .we_i    (adv && s1_q.valid && s1_q.is_pix),
    .waddr_i (s1_col_q),
    .wdata_i (s1_pix_q),
    .re_i    (in_acc && is_pix),
    .raddr_i (col_q),
    .rdata_o (up1)
  );

  mf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_b (
    .clk_i   (clk_i),
    .we_i    (adv && s1_q.valid && s1_q.is_pix),
    .waddr_i (s1_col_q),
    .wdata_i (up1),
    .re_i    (in_acc && is_pix),
    .raddr_i (col_q),
    .rdata_o (up2)
  );

  // ---------------- stage 1: window shift ----------------
  // window index is row*3+col, col 2 newest
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      window_d[i] = window_q[i];
    end
    if (cfg_we_i) begin
      for (int i = 0; i < 9; i++) begin
        window_d[i] = '0;
      end
    end else if (adv && s1_q.valid && s1_q.is_pix) begin
      window_d[0] = window_q[1];
      window_d[1] = window_q[2];
      window_d[2] = up2;
      window_d[3] = window_q[4];
      window_d[4] = window_q[5];
      window_d[5] = up1;
      window_d[6] = window_q[7];
      window_d[7] = window_q[8];
      window_d[8] = s1_pix_q;
    end
  end

  // ---------------- stage 2: sort each column ----------------
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      colsort_d[j] = sort3(window_q[j], window_q[3 + j], window_q[6 + j]);
    end
  end

  // ---------------- stage 3: median of nine ----------------
  assign med = med3(max3(colsort_q[0].lo, colsort_q[1].lo, colsort_q[2].lo),
                    med3(colsort_q[0].mid, colsort_q[1].mid, colsort_q[2].mid),
                    min3(colsort_q[0].hi, colsort_q[1].hi, colsort_q[2].hi));

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q     <= AW'(RESET_W - 1);
      h_last_q     <= ROW_W'(RESET_HEIGHT - 1);
      col_q        <= '0;
      row_q        <= '0;
      flush_q      <= '0;
      s1_q         <= '0;
      s2_q         <= '0;
      s3_q         <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        window_q[i] <= '0;
      end
    end else begin
      w_last_q <= w_last_d;
      h_last_q <= h_last_d;
      col_q    <= col_d;
      row_q    <= row_d;
      flush_q  <= flush_d;
      for (int i = 0; i < 9; i++) begin
        window_q[i] <= window_d[i];
      end
      if (adv) begin
        s1_q        <= s0_ctrl;
        s2_q        <= s1_q;
        s3_q        <= s2_q;
        out_valid_q <= s3_q.valid;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_col_q     <= col_q;
      s1_pix_q     <= pix_in;
      for (int j = 0; j < 3; j++) begin
        colsort_q[j] <= colsort_d[j];
      end
      out_pix_q    <= s3_q.need_med ? med : '0;
      out_ovalid_q <= s3_q.ovalid;
      out_olast_q  <= s3_q.olast;
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.out_pixel = out_pix_q;
  assign out_if.out_valid = out_ovalid_q;
  assign out_if.out_last  = out_olast_q;

  // ---------------- assertions ----------------
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= w_last_q)
    else $error("column counter past last column");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= h_last_q)
    else $error("row counter past last row");

  a_flush_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q <= FLUSH_W'(w_last_q) + FLUSH_W'(2))
    else $error("flush count above W + 1");

  a_owed_no_median: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && flush_owed) |=> (s1_q.valid && s1_q.ovalid && !s1_q.need_med))
    else $error("word taken while tail owed must give a border result");

  a_stall_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!adv && !cfg_we_i) |=> ($stable(s1_q) && (window_q[8] == $past(window_q[8]))))
    else $error("pipeline moved during an output stall");

endmodule

`default_nettype wire

### sim/tb.sv
// Self-checking bench for median_filter_3x3_unit: a directed table, extreme geometries, then
// random frames; typed table rows are checked against their entry, other words against a
// cycle-free model of the line buffers and 3x3 window. Uses mf_pkg, mf_if and the unit.
`timescale 1ns / 1ps

module tb;
  import mf_pkg::*;

  localparam int unsigned MAX_W         = 2048;
  localparam int unsigned RANDOM_PIXELS = 1400;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned END_WAIT      = 100000;

  typedef struct packed {
    pix_t pixel;
    logic valid;
    logic last;
  } out_word_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e                kind;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_DATA_W-1:0]    wdata;
    logic                     cmd;
    pix_t                     pix;
    bit                       typed;
    out_word_t                want;
  } dir_row_t;

  localparam out_word_t NO_OUT    = '{pixel: 8'h00, valid: 1'b0, last: 1'b0};
  localparam out_word_t BORDER    = '{pixel: 8'h00, valid: 1'b1, last: 1'b0};
  localparam out_word_t TAIL_LAST = '{pixel: 8'h00, valid: 1'b1, last: 1'b1};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  mf_in_if  in_bus ();
  mf_out_if out_bus ();

  median_filter_3x3_unit #(
    .MAX_WIDTH (MAX_W),
    .PIXEL_BITS(PIX_W)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_bus),
    .out_if     (out_bus)
  );

  always #5 clk_i = ~clk_i;

  // model state: geometry registers, two line buffers, window, raster counters
  logic [IMG_W_BITS-1:0] geom_w;
  logic [IMG_H_BITS-1:0] geom_h;
  pix_t                  lb_near [MAX_W];
  pix_t                  lb_far  [MAX_W];
  pix_t                  win     [9];
  int unsigned           col_q;
  int unsigned           row_q;
  int unsigned           tail_owed;

  out_word_t   pending_out [$];
  dir_row_t    dir_tab [$];
  int unsigned err_count;
  int          burst_left;
  int unsigned pixels_sent;

  task automatic flag_error(input string msg);
    if (err_count < 40) $display("ERROR at %0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic int unsigned eff_w();
    int unsigned w;
    w = geom_w;
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic int unsigned eff_h();
    int unsigned h;
    h = geom_h;
    if (h < MIN_DIM) h = MIN_DIM;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  function automatic pix_t window_median();
    pix_t s [9];
    pix_t t;
    for (int i = 0; i < 9; i++) s[i] = win[i];
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8 - i; j++) begin
        if (s[j] > s[j+1]) begin
          t = s[j];
          s[j] = s[j+1];
          s[j+1] = t;
        end
      end
    end
    return s[4];
  endfunction

  // one accepted input word -> the output word it causes
  function automatic out_word_t filter_step(input logic cmd, input pix_t pix);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    pix_t        up1;
    pix_t        up2;
    out_word_t   res;
    w = eff_w();
    h = eff_h();
    res = NO_OUT;
    // tail of the previous frame goes first, whatever the word is
    if (tail_owed > 0) begin
      tail_owed--;
      res.valid = 1'b1;
      res.last  = (tail_owed == 0);
    end
    if (cmd == CMD_PIXEL) begin
      c = (col_q >= w) ? w - 1 : col_q;
      r = (row_q >= h) ? h - 1 : row_q;
      up1 = lb_near[c];
      up2 = lb_far[c];
      lb_far[c]  = up1;
      lb_near[c] = pix;
      win[0] = win[1]; win[1] = win[2]; win[2] = up2;
      win[3] = win[4]; win[4] = win[5]; win[5] = up1;
      win[6] = win[7]; win[7] = win[8]; win[8] = pix;
      if (!res.valid && (r >= 2 || (r == 1 && c >= 1))) begin
        res.valid = 1'b1;
        if (r >= 2 && c >= 2) res.pixel = window_median();
      end
      if (c + 1 >= w) begin
        col_q = 0;
        if (r + 1 >= h) begin
          row_q     = 0;
          tail_owed = w + 1;
        end else begin
          row_q = r + 1;
        end
      end else begin
        col_q = c + 1;
      end
    end
    return res;
  endfunction

  function automatic pix_t rand_pix();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return pix_t'($urandom_range(100, 103));  // ties in the window
      default: return pix_t'($urandom);
    endcase
  endfunction

  function automatic void add_word(input logic cmd, input pix_t pix, input bit typed,
                                   input out_word_t want);
    dir_row_t row;
    row.kind  = ROW_WORD;
    row.idx   = REG_IMAGE_WIDTH;
    row.wdata = '0;
    row.cmd   = cmd;
    row.pix   = pix;
    row.typed = typed;
    row.want  = want;
    dir_tab.push_back(row);
  endfunction

  function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
    dir_row_t row;
    row.kind  = ROW_REG;
    row.idx   = idx;
    row.wdata = val;
    row.cmd   = CMD_PIXEL;
    row.pix   = '0;
    row.typed = 1'b0;
    row.want  = NO_OUT;
    dir_tab.push_back(row);
  endfunction

  // sender: bursts of random length separated by random gaps
  task automatic push_word(input logic cmd, input pix_t pix, input bit typed = 1'b0,
                           input out_word_t want = NO_OUT);
    int        gap;
    out_word_t pred;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 12);
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(150, 500)
                                               : $urandom_range(1, 24);
    end
    in_bus.valid <= 1'b1;
    in_bus.cmd   <= cmd;
    in_bus.pixel <= pix;
    @(posedge clk_i);
    while (in_bus.ready !== 1'b1) @(posedge clk_i);
    pred = filter_step(cmd, pix);
    pending_out.push_back(typed ? want : pred);
    if (cmd == CMD_PIXEL) pixels_sent++;
    burst_left--;
  endtask

  // register write, only once every owed word is out
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_bus.valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) geom_w = val[IMG_W_BITS-1:0];
    else                        geom_h = val[IMG_H_BITS-1:0];
    for (int i = 0; i < 9; i++) win[i] = '0;
    col_q     = 0;
    row_q     = 0;
    tail_owed = 0;
  endtask

  // full frame plus its flush tail; the tail is sometimes cut short or padded
  task automatic send_frame(input bit noisy);
    int unsigned w;
    int unsigned h;
    int          n;
    w = eff_w();
    h = eff_h();
    for (int unsigned i = 0; i < w * h; i++) begin
      if (noisy && $urandom_range(0, 39) == 0) push_word(CMD_FLUSH, rand_pix());
      push_word(CMD_PIXEL, rand_pix());
    end
    n = w + 1;
    case ($urandom_range(0, 9))
      0: n -= $urandom_range(1, w);
      1: n += $urandom_range(1, 3);
      default: ;
    endcase
    repeat (n) push_word(CMD_FLUSH, pix_t'($urandom));
  endtask

  // receiver: ready follows one of four patterns, picked anew whenever its random run ends
  initial begin
    out_word_t   want;
    int unsigned rx_cyc;
    int unsigned rx_mode;
    int unsigned rx_left;
    rx_cyc  = 0;
    rx_mode = 0;
    rx_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        if (pending_out.size() == 0) begin
          flag_error("output word with nothing expected");
        end else begin
          want = pending_out.pop_front();
          if (out_bus.out_pixel !== want.pixel)
            flag_error($sformatf("out_pixel %0h, expected %0h", out_bus.out_pixel, want.pixel));
          if (out_bus.out_valid !== want.valid)
            flag_error($sformatf("out_valid %0b, expected %0b", out_bus.out_valid, want.valid));
          if (out_bus.out_last !== want.last)
            flag_error($sformatf("out_last %0b, expected %0b", out_bus.out_last, want.last));
        end
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(64, 1024);
      end
      rx_left--;
      rx_cyc++;
      case (rx_mode)
        0: out_bus.ready <= 1'b1;
        1: out_bus.ready <= ($urandom_range(0, 4) != 0);
        2: out_bus.ready <= ($urandom_range(0, 2) == 0);
        default: out_bus.ready <= ((rx_cyc % 8) < 5);
      endcase
    end
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int unsigned base;
    int unsigned sel;
    int unsigned waited;
    in_bus.valid <= 1'b0;
    in_bus.cmd   <= CMD_PIXEL;
    in_bus.pixel <= '0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= REG_IMAGE_WIDTH;
    cfg_wdata_i  <= '0;
    err_count   = 0;
    burst_left  = 0;
    pixels_sent = 0;
    geom_w    = IMG_W_BITS'(640);
    geom_h    = IMG_H_BITS'(RESET_HEIGHT);
    col_q     = 0;
    row_q     = 0;
    tail_owed = 0;
    for (int i = 0; i < 9; i++) win[i] = '0;
    for (int i = 0; i < MAX_W; i++) begin
      lb_near[i] = '0;
      lb_far[i]  = '0;
    end

    // after reset, 640 wide: startup words carry nothing; a lone flush carries nothing
    add_word(CMD_PIXEL, 8'h00, 1'b1, NO_OUT);
    add_word(CMD_PIXEL, 8'hFF, 1'b1, NO_OUT);
    add_word(CMD_FLUSH, 8'h00, 1'b1, NO_OUT);
    // zero geometry clamps to 3x3
    add_reg(REG_IMAGE_WIDTH, 13'd0);
    add_reg(REG_IMAGE_HEIGHT, 13'd0);
    add_word(CMD_PIXEL, 8'h10, 1'b1, NO_OUT);
    add_word(CMD_PIXEL, 8'hFF, 1'b1, NO_OUT);
    add_word(CMD_PIXEL, 8'h00, 1'b1, NO_OUT);
    add_word(CMD_PIXEL, 8'h80, 1'b1, NO_OUT);
    add_word(CMD_PIXEL, 8'h55, 1'b1, BORDER);
    add_word(CMD_PIXEL, 8'hAA, 1'b1, BORDER);
    add_word(CMD_PIXEL, 8'h01, 1'b1, BORDER);
    add_word(CMD_PIXEL, 8'h7F, 1'b1, BORDER);
    add_word(CMD_PIXEL, 8'hFE, 1'b0, NO_OUT);  // the only interior position
    add_word(CMD_FLUSH, 8'hFF, 1'b1, BORDER);
    add_word(CMD_FLUSH, 8'h00, 1'b1, BORDER);
    add_word(CMD_FLUSH, 8'hFF, 1'b1, BORDER);
    // pixel arrives with one tail word still owed
    add_word(CMD_PIXEL, 8'h33, 1'b1, TAIL_LAST);
    add_word(CMD_FLUSH, 8'h00, 1'b1, NO_OUT);
    // all-ones writes clamp to the maximum geometry
    add_reg(REG_IMAGE_WIDTH, 13'h1FFF);
    add_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
    add_word(CMD_PIXEL, 8'hAA, 1'b1, NO_OUT);
    add_word(CMD_PIXEL, 8'h55, 1'b1, NO_OUT);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_REG) set_reg(dir_tab[i].idx, dir_tab[i].wdata);
      else push_word(dir_tab[i].cmd, dir_tab[i].pix, dir_tab[i].typed, dir_tab[i].want);
    end

    // widest row, then tallest column, then a few words at exact maximum values;
    // each frame is cut short by the next register write
    set_reg(REG_IMAGE_WIDTH, 13'h1FFF);
    set_reg(REG_IMAGE_HEIGHT, 13'd3);
    repeat (40) push_word(CMD_PIXEL, rand_pix());
    set_reg(REG_IMAGE_WIDTH, 13'd3);
    set_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
    repeat (30) push_word(CMD_PIXEL, rand_pix());
    set_reg(REG_IMAGE_WIDTH, 13'd2048);
    set_reg(REG_IMAGE_HEIGHT, 13'd4096);
    repeat (40) push_word(CMD_PIXEL, rand_pix());

    base = pixels_sent;
    while (pixels_sent - base < RANDOM_PIXELS) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        // below-minimum geometry
        set_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(0, 2)));
        set_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(0, 2)));
        repeat ($urandom_range(1, 3)) send_frame(1'b1);
      end else if (sel == 1) begin
        // arbitrary register values; frame abandoned part way
        set_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom));
        set_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom));
        repeat ($urandom_range(5, 80)) begin
          if ($urandom_range(0, 5) == 0) push_word(CMD_FLUSH, rand_pix());
          else push_word(CMD_PIXEL, rand_pix());
        end
      end else begin
        if (eff_w() > 12 || $urandom_range(0, 3) != 0)
          set_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(3, 12)));
        if (eff_h() > 8 || $urandom_range(0, 1) != 0)
          set_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(3, 8)));
        repeat ($urandom_range(1, 3)) send_frame(1'b1);
      end
    end

    in_bus.valid <= 1'b0;
    waited = 0;
    while (pending_out.size() != 0 && waited < END_WAIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_out.size() != 0)
      flag_error($sformatf("%0d output words never arrived", pending_out.size()));
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### median_filter_3x3_unit.f
rtl/mf_pkg.sv
rtl/mf_if.sv
rtl/mf_ram.sv
rtl/median_filter_3x3_unit.sv
sim/tb.sv
